// ----- sv/pip_pkg.sv -----
// Shared types and constants for the point-in-polygon block.
// Used by every module of the block and by pip_vertex_if; depends on nothing.
package pip_pkg;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int TOUCH_BITS = 15;
  localparam logic [TOUCH_BITS-1:0] TOUCH_RESET = 15'd20;
  localparam int QUEUE_DEPTH = 4;

  // Kind of work a vertex beat asks of the back end.
  typedef enum logic [1:0] {
    OP_OPEN,
    OP_EDGE,
    OP_CLOSE,
    OP_TOUCH
  } op_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// ----- sv/pip_vertex_if.sv -----
// Input channel: query point plus one polygon vertex per beat.
// Depends on pip_pkg for the default coordinate width.
interface pip_vertex_if #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         first_vertex;
  logic                         last_vertex;

  modport source (
    output valid, point_x, point_y, vertex_x, vertex_y, first_vertex, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, vertex_x, vertex_y, first_vertex, last_vertex,
    output ready
  );
endinterface

// ----- sv/pip_result_if.sv -----
// Output channel: one inside/outside verdict per polygon.
// Stands alone; no package items are needed.
interface pip_result_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

// ----- sv/pip_queue.sv -----
// Small register queue that decouples the front end from the back end.
// Depends on pip_pkg for the depth and the status struct.
module pip_queue #(
  parameter int DATA_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [DATA_BITS-1:0]     wdata,
  input  logic                     pop,
  output logic [DATA_BITS-1:0]     rdata,
  output pip_pkg::q_status_t       status
);

  localparam int DEPTH = pip_pkg::QUEUE_DEPTH;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] slots [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [CNT_BITS-1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rdata        = slots[rd_ptr];
  assign status.valid = (count != '0);
  assign status.full  = (count == CNT_BITS'(DEPTH));

endmodule

// ----- sv/pip_front.sv -----
// Front end: accepts vertex beats, tracks the first and previous vertex
// and turns each beat into a classified job of multiplier operands.
// Depends on pip_pkg and pip_vertex_if.
module pip_front #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEFAULT,
  localparam int DW = COORD_BITS + 1,
  localparam int JOB_BITS = 8 * DW + 4 + $bits(pip_pkg::op_t)
) (
  input  logic                 clk,
  input  logic                 rst,
  pip_vertex_if.sink           vtx,
  input  pip_pkg::q_status_t   q_stat,
  output logic                 q_push,
  output logic [JOB_BITS-1:0]  job
);

  typedef struct packed {
    pip_pkg::op_t           op;
    logic                   s1;
    logic                   n1;
    logic                   s2;
    logic                   n2;
    logic signed [DW-1:0]   m1a;
    logic signed [DW-1:0]   m1b;
    logic signed [DW-1:0]   m2a;
    logic signed [DW-1:0]   m2b;
    logic signed [DW-1:0]   m3a;
    logic signed [DW-1:0]   m3b;
    logic signed [DW-1:0]   m4a;
    logic signed [DW-1:0]   m4b;
  } job_t;

  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] prior_x;
  logic signed [COORD_BITS-1:0] prior_y;

  logic signed [DW-1:0] x, y, vx, vy, px, py, sx, sy;
  logic signed [DW-1:0] d1, d2;
  job_t                 j;

  assign vtx.ready = !q_stat.full;
  assign q_push    = vtx.valid && vtx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      prior_x <= '0;
      prior_y <= '0;
    end else if (q_push) begin
      if (vtx.first_vertex) begin
        start_x <= vtx.vertex_x;
        start_y <= vtx.vertex_y;
      end
      prior_x <= vtx.vertex_x;
      prior_y <= vtx.vertex_y;
    end
  end

  assign x  = {vtx.point_x[COORD_BITS-1], vtx.point_x};
  assign y  = {vtx.point_y[COORD_BITS-1], vtx.point_y};
  assign vx = {vtx.vertex_x[COORD_BITS-1], vtx.vertex_x};
  assign vy = {vtx.vertex_y[COORD_BITS-1], vtx.vertex_y};
  assign px = {prior_x[COORD_BITS-1], prior_x};
  assign py = {prior_y[COORD_BITS-1], prior_y};
  assign sx = {start_x[COORD_BITS-1], start_x};
  assign sy = {start_y[COORD_BITS-1], start_y};
  assign d1 = py - vy;
  assign d2 = vy - sy;

  always_comb begin
    unique case ({vtx.first_vertex, vtx.last_vertex})
      2'b00:   j.op = pip_pkg::OP_EDGE;
      2'b01:   j.op = pip_pkg::OP_CLOSE;
      2'b10:   j.op = pip_pkg::OP_OPEN;
      default: j.op = pip_pkg::OP_TOUCH;
    endcase
    // Edge from the previous vertex to this one.
    j.s1  = (vy > y) != (py > y);
    j.n1  = d1[DW-1];
    j.m1a = x - vx;
    j.m1b = d1;
    j.m2a = px - vx;
    j.m2b = y - vy;
    // Closing edge from this vertex back to the first one.
    j.s2  = (sy > y) != (vy > y);
    j.n2  = d2[DW-1];
    j.m3a = x - sx;
    j.m3b = d2;
    j.m4a = vx - sx;
    j.m4b = y - sy;
    // A single-vertex shape reuses the first two multipliers for squares.
    if (j.op == pip_pkg::OP_TOUCH) begin
      j.m1b = x - vx;
      j.m2a = y - vy;
    end
    job = j;
  end

endmodule

// ----- sv/pip_back.sv -----
// Back end: multiplies the job operands, compares the products, keeps the
// crossing parity and holds the result beat. Holds the touch distance.
// Depends on pip_pkg and pip_result_if.
module pip_back #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEFAULT,
  localparam int DW = COORD_BITS + 1,
  localparam int JOB_BITS = 8 * DW + 4 + $bits(pip_pkg::op_t)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pip_pkg::TOUCH_BITS-1:0]     cfg_data,
  input  logic [JOB_BITS-1:0]                job,
  input  pip_pkg::q_status_t                 q_stat,
  output logic                               q_pop,
  pip_result_if.source                       res
);

  localparam int PW = 2 * DW;
  localparam int TW = 2 * pip_pkg::TOUCH_BITS;
  localparam int SW = (PW + 1 > TW) ? PW + 1 : TW;

  typedef struct packed {
    pip_pkg::op_t           op;
    logic                   s1;
    logic                   n1;
    logic                   s2;
    logic                   n2;
    logic signed [DW-1:0]   m1a;
    logic signed [DW-1:0]   m1b;
    logic signed [DW-1:0]   m2a;
    logic signed [DW-1:0]   m2b;
    logic signed [DW-1:0]   m3a;
    logic signed [DW-1:0]   m3b;
    logic signed [DW-1:0]   m4a;
    logic signed [DW-1:0]   m4b;
  } job_t;

  job_t                             j;
  logic [pip_pkg::TOUCH_BITS-1:0]   touch_distance;
  logic [TW-1:0]                    touch_sq;
  logic                             busy;
  pip_pkg::op_t                     op;
  logic                             s1, n1, s2, n2;
  logic signed [PW-1:0]             p1, p2, p3, p4;
  logic                             parity;
  logic                             parity_next;
  logic                             has_res;
  logic                             advance;
  logic                             c1, c2, near;
  logic [SW-1:0]                    dist_sq;

  assign j = job_t'(job);

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_distance <= pip_pkg::TOUCH_RESET;
    end else if (cfg_write) begin
      touch_distance <= cfg_data;
    end
  end

  assign has_res = (op == pip_pkg::OP_CLOSE) || (op == pip_pkg::OP_TOUCH);
  assign advance = busy && (!has_res || !res.valid || res.ready);
  assign q_pop   = q_stat.valid && (!busy || advance);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op       <= j.op;
      s1       <= j.s1;
      n1       <= j.n1;
      s2       <= j.s2;
      n2       <= j.n2;
      p1       <= PW'(j.m1a) * PW'(j.m1b);
      p2       <= PW'(j.m2a) * PW'(j.m2b);
      p3       <= PW'(j.m3a) * PW'(j.m3b);
      p4       <= PW'(j.m4a) * PW'(j.m4b);
      touch_sq <= TW'(touch_distance) * TW'(touch_distance);
    end
  end

  always_comb begin
    c1      = s1 && (n1 ? (p1 > p2) : (p1 < p2));
    c2      = s2 && (n2 ? (p3 > p4) : (p3 < p4));
    dist_sq = SW'($unsigned(p1)) + SW'($unsigned(p2));
    near    = dist_sq <= SW'(touch_sq);
    unique case (op)
      pip_pkg::OP_OPEN:  parity_next = 1'b0;
      pip_pkg::OP_EDGE:  parity_next = parity ^ c1;
      pip_pkg::OP_CLOSE: parity_next = parity ^ c1 ^ c2;
      default:           parity_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      parity    <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (advance) begin
        busy <= 1'b0;
      end
      if (advance) begin
        parity <= parity_next;
      end
      if (advance && has_res) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_res) begin
      res.inside_res <= (op == pip_pkg::OP_TOUCH) ? near : parity_next;
    end
  end

endmodule

// ----- sv/point_in_polygon_test.sv -----
// Top level of the streaming point-in-polygon test.
// Depends on pip_pkg, pip_vertex_if, pip_result_if, pip_queue, pip_front, pip_back.
//
// Usage: each beat on vtx carries the query point and one polygon vertex,
// with first_vertex marking the start of a polygon and last_vertex its end.
// One beat on res follows every last vertex: inside_res is the ray-casting
// parity, or for a one-vertex shape whether the point lies within
// touch_distance of that vertex. touch_distance is written through
// cfg_write and cfg_data; the user must write it only while the block is idle,
// which the block itself does not enforce. Throughput is one vertex beat
// per cycle while the queue is not full. A result beat follows its last
// vertex through the queue, the multiplier registers and the result register.
// Besides the held vertices in the front end, the parity register is the only
// state carried from beat to beat.
// Reset empties the queue, clears the held vertices and the parity and sets
// touch_distance to 20. When the receiver stalls, the result beat holds,
// the queue of four jobs keeps taking vertices, and vtx.ready falls only
// once the queue is full.
module point_in_polygon_test #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  pip_vertex_if.sink                      vtx,
  pip_result_if.source                    res,
  input  logic                            cfg_write,
  input  logic [pip_pkg::TOUCH_BITS-1:0]  cfg_data
);

  localparam int DW = COORD_BITS + 1;
  localparam int JOB_BITS = 8 * DW + 4 + $bits(pip_pkg::op_t);

  logic                 q_push;
  logic                 q_pop;
  logic [JOB_BITS-1:0]  job_in;
  logic [JOB_BITS-1:0]  job_out;
  pip_pkg::q_status_t   q_stat;

  pip_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .vtx    (vtx),
    .q_stat (q_stat),
    .q_push (q_push),
    .job    (job_in)
  );

  pip_queue #(
    .DATA_BITS (JOB_BITS)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (job_in),
    .pop    (q_pop),
    .rdata  (job_out),
    .status (q_stat)
  );

  pip_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .job       (job_out),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .res       (res)
  );

  a_reset_quiet: assert property (@(posedge clk) rst |=> !res.valid && !q_stat.valid)
    else $error("result or queued job present after reset");

  a_full_refuses: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !vtx.ready)
    else $error("vertex accepted while the queue is full");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_stat.valid)
    else $error("job taken from an empty queue");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (q_stat.full && !q_pop) |=> q_stat.full)
    else $error("full queue lost a job without a pop");

endmodule
